// ===== hdl/mesi_pkg.sv =====
// shared types and codes for the mesi snooping coherence block
package mesi_pkg;

  // line states
  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_t;

  // bus transactions
  typedef enum logic [1:0] {
    BUS_NONE    = 2'd0,
    BUS_RD      = 2'd1,
    BUS_RDX     = 2'd2,
    BUS_UPGRADE = 2'd3
  } bus_op_t;

  // access kinds
  localparam logic FUNC_WRITE = 1'b1;

  // configuration registers
  localparam logic REG_ACTIVE_PROCS = 1'b0;
  localparam logic [2:0] ACTIVE_PROCS_RESET = 3'd4;

endpackage

// ===== hdl/mesi_snoop_coherence.sv =====
// mesi snooping coherence controller over several private set-associative caches
// Each accepted word is one processor's read or write. The caches of all
// processors for one set live in one row of two synchronous memories (tags, and
// state plus last-use stamp), so one item is a read of its set row followed by a
// compute-and-write-back cycle; a new word is taken only once the last has left
// that compute cycle. The result goes to an output register; a stalled result
// holds the next item in its compute cycle. After reset the state memory is
// cleared one set per cycle, a pass during which no word is accepted;
// configuration writes are taken at any time. LINE_BYTES and SETS are powers
// of two. active_procs of 0 acts as 1, above PROCS as PROCS; a requester at
// or above that count gets an all-zero result and changes nothing.
module mesi_snoop_coherence #(
  parameter int PROCS      = 4,
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32,
  parameter int STAMP_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [1:0]           in_requester,
  input  logic [ADDR_BITS-1:0] in_address,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [1:0]           out_bus_op,
  output logic                 out_snoop_flush,
  output logic                 out_victim_writeback,
  output logic [1:0]           out_line_state,
  output logic [1:0]           out_way_used,
  // configuration port
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import mesi_pkg::*;

  localparam int OFF_LOG = $clog2(LINE_BYTES);
  localparam int SET_LOG = $clog2(SETS);
  localparam int SET_W   = (SET_LOG > 0) ? SET_LOG : 1;
  localparam int TAG_W   = ADDR_BITS - OFF_LOG - SET_LOG;
  localparam int ST_W    = STAMP_BITS + 2;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NP_W    = $clog2(PROCS + 1);

  typedef logic [PROCS-1:0][WAYS-1:0][TAG_W-1:0] tag_row_t;
  // each entry: stamp above, mesi in the low two bits
  typedef logic [PROCS-1:0][WAYS-1:0][ST_W-1:0]  st_row_t;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CALC} ctl_t;

  // memories, one row per set
  tag_row_t tag_mem [SETS];
  st_row_t  st_mem  [SETS];

  ctl_t                  state_r;
  logic [SET_W-1:0]      clr_cnt_r;
  logic [2:0]            active_r;
  logic [STAMP_BITS-1:0] count_r;
  tag_row_t              tag_rd_r;
  st_row_t               st_rd_r;
  logic                  func_r;
  logic [1:0]            req_r;
  logic [SET_W-1:0]      set_r;
  logic [TAG_W-1:0]      tag_r;

  logic                  out_valid_r;
  logic                  hit_r;
  logic [1:0]            bus_r;
  logic                  flush_r;
  logic                  wb_r;
  logic [1:0]            lst_r;
  logic [1:0]            way_r;

  logic                  in_acc;
  logic                  adv;
  logic [SET_W-1:0]      in_set;
  logic [TAG_W-1:0]      in_tag;
  logic [NP_W-1:0]       nproc;
  logic                  cfg_wr;

  // results of the compute cycle
  logic                  ignore;
  logic                  c_hit;
  logic [1:0]            c_bus;
  logic                  c_flush;
  logic                  c_wb;
  logic [1:0]            c_lst;
  logic [WAY_W-1:0]      c_way;
  logic [STAMP_BITS-1:0] stamp_new;
  tag_row_t              tag_wr;
  st_row_t               st_wr;

  // address split and handshake
  assign in_set   = (SET_LOG > 0) ? SET_W'(in_address >> OFF_LOG) : '0;
  assign in_tag   = TAG_W'(in_address >> (OFF_LOG + SET_LOG));
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign adv      = (state_r == S_CALC) && (!out_valid_r || !out_stall);

  // effective participant count
  always_comb begin
    if (active_r == 3'd0) begin
      nproc = NP_W'(1);
    end else if (32'(active_r) > PROCS) begin
      nproc = NP_W'(PROCS);
    end else begin
      nproc = NP_W'(active_r);
    end
  end

  // lookup, snoop and replacement for one access
  always_comb begin
    logic              found;
    logic              others;
    logic              inv_found;
    logic [WAY_W-1:0]  best;
    logic [1:0]        cur;
    st_row_t           row;
    row       = st_rd_r;
    tag_wr    = tag_rd_r;
    ignore    = ({{(NP_W > 2 ? NP_W - 2 : 0){1'b0}}, req_r} >= nproc);
    c_hit     = 1'b0;
    c_bus     = BUS_NONE;
    c_flush   = 1'b0;
    c_wb      = 1'b0;
    c_lst     = ST_I;
    c_way     = '0;
    others    = 1'b0;
    cur       = ST_I;
    stamp_new = count_r + 1'b1;
    // own lookup
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row[req_r][w][1:0] != ST_I && tag_rd_r[req_r][w] == tag_r) begin
        c_hit = 1'b1;
        c_way = WAY_W'(w);
      end
    end
    // snoop the other caches
    for (int p = 0; p < PROCS; p++) begin
      found = 1'b0;
      if (p < int'(nproc) && p != int'(req_r) &&
          !(c_hit && !(func_r == FUNC_WRITE && row[req_r][c_way][1:0] == ST_S))) begin
        for (int w = 0; w < WAYS; w++) begin
          if (!found && row[p][w][1:0] != ST_I && tag_rd_r[p][w] == tag_r) begin
            found  = 1'b1;
            others = 1'b1;
            cur    = row[p][w][1:0];
            if (cur == ST_M && !c_hit) c_flush = 1'b1;
            if (func_r == FUNC_WRITE) begin
              row[p][w][1:0] = ST_I;
            end else if (cur == ST_M || cur == ST_E) begin
              row[p][w][1:0] = ST_S;
            end
          end
        end
      end
    end
    // victim: lowest invalid way, else oldest stamp
    inv_found = 1'b0;
    best      = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (st_rd_r[req_r][w][1:0] == ST_I) begin
        inv_found = 1'b1;
        best      = WAY_W'(w);
      end
    end
    if (!inv_found) begin
      for (int w = 1; w < WAYS; w++) begin
        if (st_rd_r[req_r][w][ST_W-1:2] < st_rd_r[req_r][best][ST_W-1:2]) begin
          best = WAY_W'(w);
        end
      end
    end
    if (c_hit) begin
      if (func_r == FUNC_WRITE) begin
        if (row[req_r][c_way][1:0] == ST_S) c_bus = BUS_UPGRADE;
        row[req_r][c_way][1:0] = ST_M;
      end
      c_lst = row[req_r][c_way][1:0];
    end else begin
      c_way = best;
      c_wb  = (st_rd_r[req_r][best][1:0] == ST_M);
      if (func_r == FUNC_WRITE) begin
        c_bus = BUS_RDX;
        c_lst = ST_M;
      end else begin
        c_bus = BUS_RD;
        c_lst = others ? ST_S : ST_E;
      end
      tag_wr[req_r][best]      = tag_r;
      row[req_r][best][1:0]    = c_lst;
    end
    row[req_r][c_way][ST_W-1:2] = stamp_new;
    st_wr = row;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      st_mem[clr_cnt_r] <= '0;
    end else if (adv && !ignore) begin
      st_mem[set_r]  <= st_wr;
      tag_mem[set_r] <= tag_wr;
    end
    if (in_acc) begin
      st_rd_r  <= st_mem[in_set];
      tag_rd_r <= tag_mem[in_set];
      func_r   <= in_func;
      req_r    <= in_requester;
      set_r    <= in_set;
      tag_r    <= in_tag;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (32'(clr_cnt_r) == SETS - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) state_r <= S_CALC;
        end
        S_CALC: begin
          if (adv) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (adv) begin
        out_valid_r <= 1'b1;
        if (!ignore) count_r <= stamp_new;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r   <= ignore ? 1'b0 : c_hit;
      bus_r   <= ignore ? BUS_NONE : c_bus;
      flush_r <= ignore ? 1'b0 : c_flush;
      wb_r    <= ignore ? 1'b0 : (c_wb && !c_hit);
      lst_r   <= ignore ? ST_I : c_lst;
      way_r   <= ignore ? 2'd0 : 2'(c_way);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = hit_r;
  assign out_bus_op           = bus_r;
  assign out_snoop_flush      = flush_r;
  assign out_victim_writeback = wb_r;
  assign out_line_state       = lst_r;
  assign out_way_used         = way_r;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_PROCS_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_ACTIVE_PROCS) begin
      active_r <= cfg_pwdata[2:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE_PROCS) ? {29'd0, active_r} : 32'd0;

`ifndef SYNTHESIS
  // no word enters during the clearing pass
  a_no_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_acc) else $error("word accepted while clearing");
  // a held result is not overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !adv) else $error("result overwritten");
  // a hit never needs a read-exclusive
  a_hit_no_rdx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hit_r |-> bus_r != BUS_RDX && !wb_r) else $error("bad hit result");
  // finished compute returns to idle
  a_calc_done: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> state_r == S_IDLE && out_valid_r) else $error("compute did not retire");
`endif

endmodule
